[sv/dpa_pkg.sv]
package dpa_pkg;

    // Q16.16 value and full product types
    typedef logic signed [31:0] t_q;
    typedef logic signed [63:0] t_prod;
    typedef logic signed [47:0] t_wide;

    localparam int unsigned Q_FRAC = 16;
    localparam int unsigned ALPHA_W = 17;
    localparam int unsigned LIMIT_W = 31;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
    localparam t_wide Q_MAX_W = 48'sd2147483647;
    localparam t_wide Q_MIN_W = -48'sd2147483648;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_TS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD_TS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KB_TS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FILT_EN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WINDUP   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd7;

    // Clip a wide value to the signed 32-bit range
    function automatic t_q sat_q(input t_wide v);
        t_q res;
        if (v > Q_MAX_W) begin
            res = 32'sh7fffffff;
        end else if (v < Q_MIN_W) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Round half up, drop the fraction bits, then clip
    function automatic t_q round_q(input t_prod p);
        t_prod r;
        r = (p + 64'sd32768) >>> Q_FRAC;
        return sat_q(r[47:0]);
    endfunction

endpackage

[sv/discrete_pid_antiwindup.sv]
// PID controller with optional derivative filter and back-calculation
// anti-windup, signed Q16.16 throughout.
// Input channel: i_in_valid / o_in_ready carry one control tick
// (i_target_value, i_measured_value). Output channel: o_out_valid /
// i_out_ready carry one result (o_drive_magnitude, o_drive_forward).
// Configuration: write i_cfg_wdata to register i_cfg_index while
// i_cfg_wr_en is high; only while the controller is idle.
// Sequencing: one 32x32 multiplier is shared by all terms under a sequencer.
// A tick steps through the P, I and D products, the filter steps when the
// derivative filter is on, the sum, the anti-windup steps when it is on and
// the output step. Input ready is low while a tick is in work.
// The result sits in an output register; the next tick is accepted while
// it waits. If the receiver still stalls when the following result is
// done, the sequencer holds until the register is free.
// Reset (synchronous, active low) loads the register defaults, clears the
// integral, previous error and filtered derivative, and empties the output.
module discrete_pid_antiwindup (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [dpa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dpa_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  dpa_pkg::t_q                       i_target_value,
    input  dpa_pkg::t_q                       i_measured_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [dpa_pkg::LIMIT_W-1:0]       o_drive_magnitude,
    output logic                              o_drive_forward
);
    import dpa_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MP   = 4'd1;
    localparam logic [3:0] S_MI   = 4'd2;
    localparam logic [3:0] S_MD   = 4'd3;
    localparam logic [3:0] S_F1   = 4'd4;
    localparam logic [3:0] S_F2   = 4'd5;
    localparam logic [3:0] S_F3   = 4'd6;
    localparam logic [3:0] S_SUM  = 4'd7;
    localparam logic [3:0] S_W1   = 4'd8;
    localparam logic [3:0] S_W2   = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    // Configuration
    t_q                  r_kp, r_ki, r_kd, r_kb;
    logic [ALPHA_W-1:0]  r_alpha;
    logic                r_filt_en, r_windup_en;
    logic [LIMIT_W-1:0]  r_limit;

    // Controller state
    t_q r_integral, r_prev_err, r_prev_fd;

    // Working registers
    logic [3:0]          r_state, n_state;
    t_q                  r_err, r_up, r_ui, r_ud;
    t_prod               r_acc;
    logic signed [33:0]  r_u;
    logic                r_out_valid;
    logic [LIMIT_W-1:0]  r_mag;
    logic                r_fwd;

    // Shared multiplier operands and result
    t_q    mul_a, mul_b;
    t_prod prod;

    logic                in_fire, out_free;
    logic [ALPHA_W-1:0]  alpha_c;
    t_q                  d_err;
    t_q                  filt_q;
    t_wide               u_w, lim_w, u_sat, u_abs;
    t_q                  excess;
    logic [LIMIT_W-1:0]  mag_c;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Datapath helpers
    always_comb begin
        alpha_c = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
        d_err   = sat_q(48'(r_err) - 48'(r_prev_err));
        filt_q  = round_q(r_acc + prod);
        u_w     = 48'(r_u);
        lim_w   = {17'b0, r_limit};
        if (u_w > lim_w) begin
            u_sat = lim_w;
        end else if (u_w < -lim_w) begin
            u_sat = -lim_w;
        end else begin
            u_sat = u_w;
        end
        excess = sat_q(u_sat - u_w);
        u_abs  = (u_w < 0) ? -u_w : u_w;
        mag_c  = (u_abs > lim_w) ? r_limit : u_abs[LIMIT_W-1:0];
    end

    // Select multiplier operands by step
    always_comb begin
        mul_a = r_kp;
        mul_b = r_err;
        case (r_state)
            S_MI: begin
                mul_a = r_ki;
                mul_b = r_err;
            end
            S_MD: begin
                mul_a = r_kd;
                mul_b = d_err;
            end
            S_F1: begin
                mul_a = r_prev_fd;
                mul_b = 32'(ALPHA_ONE - alpha_c);
            end
            S_F2: begin
                mul_a = r_ud;
                mul_b = 32'(alpha_c);
            end
            S_W1: begin
                mul_a = r_kb;
                mul_b = excess;
            end
            default: begin
                mul_a = r_kp;
                mul_b = r_err;
            end
        endcase
    end

    dpa_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_fire) n_state = S_MP;
            S_MP:   n_state = S_MI;
            S_MI:   n_state = S_MD;
            S_MD:   n_state = S_F1;
            S_F1:   n_state = r_filt_en ? S_F2 : S_SUM;
            S_F2:   n_state = S_F3;
            S_F3:   n_state = S_SUM;
            S_SUM:  n_state = r_windup_en ? S_W1 : S_OUT;
            S_W1:   n_state = S_W2;
            S_W2:   n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_kp        <= 32'sd65536;
            r_ki        <= 32'sd655;
            r_kd        <= 32'sd0;
            r_alpha     <= '0;
            r_kb        <= 32'sd655;
            r_filt_en   <= 1'b0;
            r_windup_en <= 1'b1;
            r_limit     <= 31'd21692416;
            r_integral  <= '0;
            r_prev_err  <= '0;
            r_prev_fd   <= '0;
        end else begin
            r_state <= n_state;
            // Take a register write
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_KP:      r_kp        <= i_cfg_wdata;
                    REG_KI_TS:   r_ki        <= i_cfg_wdata;
                    REG_KD_TS:   r_kd        <= i_cfg_wdata;
                    REG_ALPHA:   r_alpha     <= i_cfg_wdata[ALPHA_W-1:0];
                    REG_KB_TS:   r_kb        <= i_cfg_wdata;
                    REG_FILT_EN: r_filt_en   <= i_cfg_wdata[0];
                    REG_WINDUP:  r_windup_en <= i_cfg_wdata[0];
                    REG_LIMIT:   r_limit     <= i_cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            // Update the filtered derivative
            if (r_state == S_F3) begin
                r_prev_fd <= filt_q;
            end
            // Commit the tick and load the result
            if (r_state == S_OUT && out_free) begin
                r_integral  <= r_ui;
                r_prev_err  <= r_err;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (in_fire) r_err <= sat_q(48'(i_target_value) - 48'(i_measured_value));
            S_MI:   r_up <= round_q(prod);
            S_MD:   r_ui <= sat_q(48'(r_integral) + 48'(round_q(prod)));
            S_F1:   r_ud <= round_q(prod);
            S_F2:   r_acc <= prod;
            S_F3:   r_ud <= filt_q;
            S_SUM: begin
                r_u <= 34'(48'(r_up) + 48'(r_ui) + 48'(r_ud));
            end
            S_W2:   r_ui <= sat_q(48'(r_ui) + 48'(round_q(prod)));
            S_OUT: begin
                if (out_free) begin
                    r_mag <= mag_c;
                    r_fwd <= !r_u[33];
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_drive_magnitude = r_mag;
    assign o_drive_forward   = r_fwd;

endmodule

[sv/dpa_mul.sv]
module dpa_mul (
    input  logic          i_clk,
    input  dpa_pkg::t_q    i_a,
    input  dpa_pkg::t_q    i_b,
    output dpa_pkg::t_prod o_prod
);
    import dpa_pkg::*;

    t_prod r_prod;
    t_prod n_prod;

    // Full signed product, registered
    always_comb begin
        n_prod = 64'(i_a) * 64'(i_b);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

[sv/dpa_checker.sv]
module dpa_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [dpa_pkg::LIMIT_W-1:0]       o_drive_magnitude,
    input logic                              o_drive_forward
);
    import dpa_pkg::*;

    // Reset empties the output and opens the input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output not empty or input not ready after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_drive_magnitude) && $stable(o_drive_forward))
        else $error("stalled result changed");

    // An accepted tick makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after accepting a tick");

    // A new result only follows a busy cycle
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without work");

endmodule

bind discrete_pid_antiwindup dpa_checker u_dpa_checker (.*);

[bench/tb_discrete_pid_antiwindup.sv]
`timescale 1ns / 100ps

module tb_discrete_pid_antiwindup;

    import dpa_pkg::*;

    localparam int     LIMIT_CYCLES    = 400000;
    localparam int     RAND_PHASES     = 9;
    localparam int     TICKS_PER_PHASE = 161;
    localparam int     HOLD_CYCLES     = 400;
    localparam int     SETTLE_CYCLES   = 16;
    localparam longint QMAX            = 64'sd2147483647;
    localparam longint QMIN            = -64'sd2147483648;
    localparam longint UNITY           = 64'sd65536;
    localparam t_q     Q_TOP           = 32'sh7fffffff;
    localparam t_q     Q_BOTTOM        = 32'sh80000000;

    typedef struct packed {
        t_q target;
        t_q measured;
    } t_tick_req;

    typedef struct packed {
        logic [LIMIT_W-1:0] mag;
        logic               fwd;
    } t_drive;

    // DUT signals; the inputs are all known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_q                    i_target_value = '0;
    t_q                    i_measured_value = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [LIMIT_W-1:0]    o_drive_magnitude;
    logic                  o_drive_forward;

    // Stimulus and checking state
    t_tick_req tick_queue[$];
    t_drive    drive_expected[$];
    bit        tick_taken = 1'b0;
    bit        rx_hold = 1'b0;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    int        ticks_taken = 0;
    int        errors = 0;

    // Controller settings as last written
    t_q                 kp_cfg = 32'sd65536;
    t_q                 ki_cfg = 32'sd655;
    t_q                 kd_cfg = 32'sd0;
    logic [ALPHA_W-1:0] alpha_cfg = '0;
    t_q                 kb_cfg = 32'sd655;
    bit                 filt_en_cfg = 1'b0;
    bit                 windup_en_cfg = 1'b1;
    logic [LIMIT_W-1:0] limit_cfg = 31'd21692416;

    // Controller state
    t_q integ_acc = '0;
    t_q last_error = '0;
    t_q last_deriv = '0;

    discrete_pid_antiwindup u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_target_value    (i_target_value),
        .i_measured_value  (i_measured_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_drive_magnitude (o_drive_magnitude),
        .o_drive_forward   (o_drive_forward)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint clip32(longint v);
        if (v > QMAX) begin
            return QMAX;
        end else if (v < QMIN) begin
            return QMIN;
        end
        return v;
    endfunction

    // Round half up, then floor-shift out the fraction
    function automatic longint round_frac(longint p);
        return (p + 64'sd32768) >>> Q_FRAC;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return clip32(round_frac(a * b));
    endfunction

    // One control tick: advance integrator and error history, and derivative history with the filter on
    function automatic t_drive pid_tick(t_q target, t_q measured);
        longint err, p_term, i_term, d_term, u, u_sat, lim, mag, wt;
        t_drive res;
        err = clip32(longint'(target) - longint'(measured));
        p_term = qmul(longint'(kp_cfg), err);
        i_term = clip32(longint'(integ_acc) + qmul(longint'(ki_cfg), err));
        d_term = qmul(longint'(kd_cfg), clip32(err - longint'(last_error)));
        lim = longint'(limit_cfg);
        if (filt_en_cfg) begin
            wt = (alpha_cfg > ALPHA_ONE) ? UNITY : longint'(alpha_cfg);
            d_term = clip32(round_frac(longint'(last_deriv) * (UNITY - wt) + d_term * wt));
            last_deriv = t_q'(d_term);
        end
        u = p_term + i_term + d_term;
        if (windup_en_cfg) begin
            u_sat = (u > lim) ? lim : ((u < -lim) ? -lim : u);
            i_term = clip32(i_term + qmul(longint'(kb_cfg), clip32(u_sat - u)));
        end
        integ_acc = t_q'(i_term);
        last_error = t_q'(err);
        mag = (u < 0) ? -u : u;
        if (mag > lim) begin
            mag = lim;
        end
        res.mag = mag[LIMIT_W-1:0];
        res.fwd = (u >= 0);
        return res;
    endfunction

    // Drive requests at the falling edge; hold payload until accepted
    always @(negedge i_clk) begin
        t_tick_req req;
        if (i_rst_n && (!i_in_valid || tick_taken)) begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                req = tick_queue.pop_front();
                i_in_valid <= 1'b1;
                i_target_value <= req.target;
                i_measured_value <= req.measured;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        i_out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // Predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        t_drive exp_drive;
        tick_taken = i_rst_n && i_in_valid && o_in_ready;
        if (tick_taken) begin
            drive_expected.push_back(pid_tick(i_target_value, i_measured_value));
            ticks_taken++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (drive_expected.size() == 0) begin
                $error("result with no request pending: magnitude %0d forward %0b",
                       o_drive_magnitude, o_drive_forward);
                errors++;
            end else begin
                exp_drive = drive_expected.pop_front();
                if (o_drive_magnitude !== exp_drive.mag) begin
                    $error("drive_magnitude: expected %0d actual %0d",
                           exp_drive.mag, o_drive_magnitude);
                    errors++;
                end
                if (o_drive_forward !== exp_drive.fwd) begin
                    $error("drive_forward: expected %0b actual %0b",
                           exp_drive.fwd, o_drive_forward);
                    errors++;
                end
            end
        end
    end

    // Stall the receiver long enough to back up the input
    initial begin
        while (ticks_taken < 200) begin
            @(posedge i_clk);
        end
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            REG_KP:      kp_cfg = data;
            REG_KI_TS:   ki_cfg = data;
            REG_KD_TS:   kd_cfg = data;
            REG_ALPHA:   alpha_cfg = data[ALPHA_W-1:0];
            REG_KB_TS:   kb_cfg = data;
            REG_FILT_EN: filt_en_cfg = data[0];
            REG_WINDUP:  windup_en_cfg = data[0];
            REG_LIMIT:   limit_cfg = data[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(t_q kp, t_q ki, t_q kd, logic [ALPHA_W-1:0] alpha,
                                 t_q kb, bit filt_en, bit windup_en,
                                 logic [LIMIT_W-1:0] lim);
        write_reg(REG_KP, kp);
        write_reg(REG_KI_TS, ki);
        write_reg(REG_KD_TS, kd);
        write_reg(REG_ALPHA, {{(CFG_DATA_W-ALPHA_W){1'b0}}, alpha});
        write_reg(REG_KB_TS, kb);
        write_reg(REG_FILT_EN, {{(CFG_DATA_W-1){1'b0}}, filt_en});
        write_reg(REG_WINDUP, {{(CFG_DATA_W-1){1'b0}}, windup_en});
        write_reg(REG_LIMIT, {1'b0, lim});
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic push_tick(t_q target, t_q measured);
        tick_queue.push_back('{target: target, measured: measured});
    endtask

    // Drain everything, then let the sequencer settle
    task automatic wait_idle();
        while (tick_queue.size() != 0 || i_in_valid || drive_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_q rand_gain();
        int v;
        case ($urandom_range(9))
            0: return Q_TOP;
            1: return Q_BOTTOM;
            2: return t_q'($urandom);
            3: return '0;
            default: begin
                v = int'($urandom_range(0, 524288)) - 262144;
                return t_q'(v);
            end
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] rand_limit();
        case ($urandom_range(7))
            0: return '0;
            1: return 31'h7fffffff;
            2: return LIMIT_W'($urandom);
            default: return LIMIT_W'($urandom_range(0, 33554432));
        endcase
    endfunction

    function automatic t_q pick_edge();
        case ($urandom_range(3))
            0: return Q_TOP;
            1: return Q_BOTTOM;
            2: return '0;
            default: return -32'sd1;
        endcase
    endfunction

    initial begin
        int ph;
        int k;
        int set_pt;
        int noise;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 33;
        rx_idle_pct = 62;

        // Reset settings: zero error, error overflow both ways, over-limit drive
        push_tick(32'sd0, 32'sd0);
        push_tick(Q_TOP, Q_BOTTOM);
        push_tick(Q_BOTTOM, Q_TOP);
        push_tick(-32'sd1, 32'sd0);
        push_tick(32'sd1000 <<< 16, 32'sd0);
        push_tick(-(32'sd1000 <<< 16), 32'sd0);
        push_tick(32'sd5 <<< 16, 32'sd0);
        wait_idle();

        // Filter on with weight above one, derivative step overflow
        load_settings(Q_BOTTOM, 32'sd0, Q_TOP, 17'h1ffff, 32'sd655, 1'b1, 1'b1, 31'h7fffffff);
        push_tick(Q_TOP, Q_BOTTOM);
        push_tick(Q_BOTTOM, Q_TOP);
        push_tick(32'sd0, 32'sd0);
        push_tick(32'sd1 <<< 16, 32'sd0);
        wait_idle();

        // Zero limit with huge back-calculation excess
        load_settings(32'sd65536, Q_TOP, 32'sd0, 17'd32768, Q_TOP, 1'b1, 1'b1, 31'd0);
        push_tick(32'sd10 <<< 16, 32'sd0);
        push_tick(Q_BOTTOM, Q_TOP);
        push_tick(32'sd0, 32'sd0);
        push_tick(-(32'sd3 <<< 16), 32'sd0);
        wait_idle();

        // Filter off keeps the filtered derivative, no anti-windup
        load_settings(Q_BOTTOM, 32'sd655, 32'sd65536, 17'd0, Q_BOTTOM, 1'b0, 1'b0,
                      31'd21692416);
        push_tick(32'sd3 <<< 16, 32'sd0);
        push_tick(32'sd0, 32'sd3 <<< 16);
        push_tick(Q_TOP, 32'sd0);
        push_tick(32'sd0, 32'sd0);
        wait_idle();

        // Random settings; mostly set-point tracking with small noise
        set_pt = 0;
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 3) begin
                tx_idle_pct = 62;
                rx_idle_pct = 33;
            end else if (ph == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            load_settings(rand_gain(), rand_gain(), rand_gain(),
                          ALPHA_W'($urandom_range(0, 131071)), rand_gain(),
                          1'($urandom_range(1)), 1'($urandom_range(1)), rand_limit());
            for (k = 0; k < TICKS_PER_PHASE; k++) begin
                case ($urandom_range(9))
                    0: push_tick(t_q'($urandom), t_q'($urandom));
                    1: push_tick(pick_edge(), pick_edge());
                    default: begin
                        if ($urandom_range(19) == 0) begin
                            set_pt = int'($urandom_range(0, 134217728)) - 67108864;
                        end
                        noise = int'($urandom_range(0, 2097152)) - 1048576;
                        push_tick(t_q'(set_pt), t_q'(set_pt + noise));
                    end
                endcase
            end
            wait_idle();
        end

        if (errors == 0 && drive_expected.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
